[rtl/core/tph_pkg.sv]
// ----------------------------------------------------------------------------
// tph_pkg
// Shared codes, constants and controller/datapath interface types for the
// two-level perfect hash table.
// ----------------------------------------------------------------------------
package tph_pkg;

   localparam int unsigned DefMaxBuckets = 1024;
   localparam int unsigned DefSlotDepth  = 4096;

   localparam logic [2:0] OP_LOOKUP      = 3'd0;
   localparam logic [2:0] OP_INSERT      = 3'd1;
   localparam logic [2:0] OP_ERASE       = 3'd2;
   localparam logic [2:0] OP_LOAD_BUCKET = 3'd3;
   localparam logic [2:0] OP_LOAD_SLOT   = 3'd4;
   localparam logic [2:0] OP_CLEAR       = 3'd5;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_EMPTY  = 2'd1;
   localparam logic [1:0] ST_BEYOND = 2'd2;

   localparam logic [1:0] CSR_TOP_MULT    = 2'd0;
   localparam logic [1:0] CSR_TOP_ADD     = 2'd1;
   localparam logic [1:0] CSR_TOP_BUCKETS = 2'd2;

   localparam logic [32:0] HASH_PRIME = 33'h1_0000_000F;
   localparam int unsigned BktWidth   = 32 + 32 + 13 + 12;
   localparam int unsigned SlotWidth  = 32 + 1 + 1;

   typedef struct packed {
      logic       capture;
      logic       lvl;
      logic       mul_en;
      logic       div_start;
      logic       bkt_rd;
      logic       pos_en;
      logic       slot_rd;
      logic       stat_wr;
      logic [1:0] stat_val;
      logic       finish;
      logic       clr_init;
      logic       clr_step;
   } tph_cmd_type;

   typedef struct packed {
      logic div_busy;
      logic clr_last;
      logic bkt_empty;
      logic slot_ok;
   } tph_sts_type;

endpackage

[rtl/core/tph_ram.sv]
// ----------------------------------------------------------------------------
// tph_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module tph_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic             re,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/tph_div.sv]
// ----------------------------------------------------------------------------
// tph_div
// Iterative restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module tph_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [32:0] dividend,
   input  logic [12:0] divisor,
   output logic        busy,
   output logic [12:0] rem
);

   localparam logic [5:0] STEPS = 6'd33;

   logic [32:0] dvd_ff, dvd_in;
   logic [12:0] dsr_ff, dsr_in;
   logic [12:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [13:0] trial;

   always_comb begin
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, dvd_ff[32]};
      if (start) begin
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
         cnt_in  = STEPS;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[31:0], 1'b0};
         rem_in = (trial >= {1'b0, dsr_ff}) ? 13'(trial - {1'b0, dsr_ff}) : trial[12:0];
         cnt_in = cnt_ff - 6'd1;
         busy_in = (cnt_ff != 6'd1);
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   assign busy = busy_ff;
   assign rem  = rem_ff;

endmodule

[rtl/core/tph_datapath.sv]
// ----------------------------------------------------------------------------
// tph_datapath
// Hash arithmetic, bucket and slot stores, count and response registers.
// ----------------------------------------------------------------------------
module tph_datapath import tph_pkg::*; #(
   parameter int unsigned MAX_BUCKETS = DefMaxBuckets,
   parameter int unsigned SLOT_DEPTH  = DefSlotDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  tph_cmd_type cmd,
   output tph_sts_type sts,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic [2:0]  req_op,
   input  logic [31:0] req_key,
   input  logic [9:0]  req_bucket_index,
   input  logic [31:0] req_bucket_mult,
   input  logic [31:0] req_bucket_add,
   input  logic [12:0] req_bucket_slots,
   input  logic [11:0] req_bucket_base,
   input  logic [11:0] req_slot_index,
   output logic        rsp_present,
   output logic        rsp_key_match,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_stored_count
);

   localparam int unsigned BKT_AW  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
   localparam int unsigned SLOT_AW = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
   localparam int unsigned CLR_LEN = (MAX_BUCKETS > SLOT_DEPTH) ? MAX_BUCKETS : SLOT_DEPTH;
   localparam int unsigned CLR_W   = $clog2(CLR_LEN);

   logic [31:0] top_mult_ff, top_add_ff;
   logic [10:0] top_buckets_ff;

   logic [2:0]  op_ff;
   logic [31:0] key_ff, bmult_ff, badd_ff;
   logic [9:0]  bidx_ff;
   logic [12:0] bslots_ff;
   logic [11:0] bbase_ff;

   logic [31:0] prod_ff, prod_in, mul_a, add_c;
   logic [32:0] sum, red;
   logic [12:0] divisor, rem;
   logic        div_busy;

   logic [1:0]  stat_ff;
   logic [13:0] slot_pos_ff;
   logic        bkt_inrange_ff;
   logic [CLR_W-1:0] clr_ff;
   logic [15:0] count_ff, count_in;

   logic        rsp_present_ff, rsp_key_match_ff;
   logic [1:0]  rsp_status_ff;
   logic [15:0] rsp_stored_count_ff;

   logic [31:0] clr32, bidx32, b32, pos32, bkt_addr32, slot_addr32;
   logic        bkt_we, slot_we, ok, op_hit;
   logic [BktWidth-1:0]  bkt_wdata, bkt_rdata;
   logic [SlotWidth-1:0] slot_wdata, slot_rdata;
   logic [31:0] rd_mult, rd_add, rd_key;
   logic [12:0] rd_slots;
   logic [11:0] rd_base;
   logic        rd_loaded, rd_present, new_present;
   logic        present_in, match_in;

   assign {rd_mult, rd_add, rd_slots, rd_base} = bkt_rdata;
   assign {rd_key, rd_loaded, rd_present}      = slot_rdata;

   assign mul_a   = cmd.lvl ? rd_mult : top_mult_ff;
   assign add_c   = cmd.lvl ? rd_add : top_add_ff;
   assign prod_in = mul_a * key_ff;
   assign sum     = {1'b0, prod_ff} + {1'b0, add_c};
   assign red     = (sum >= HASH_PRIME) ? sum - HASH_PRIME : sum;
   assign divisor = cmd.lvl ? rd_slots
                            : ((top_buckets_ff == '0) ? 13'd1 : {2'b0, top_buckets_ff});

   tph_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (red),
      .divisor  (divisor),
      .busy     (div_busy),
      .rem      (rem)
   );

   assign clr32  = 32'(clr_ff);
   assign bidx32 = 32'(bidx_ff);
   assign b32    = 32'(rem[10:0]);
   assign pos32  = 32'(slot_pos_ff);
   assign ok     = (stat_ff == ST_OK);

   assign bkt_addr32 = cmd.clr_step ? clr32 : (cmd.finish ? bidx32 : b32);
   assign bkt_we = (cmd.clr_step && clr32 < 32'(MAX_BUCKETS))
                || (cmd.finish && op_ff == OP_LOAD_BUCKET && bidx32 < 32'(MAX_BUCKETS));
   assign bkt_wdata = cmd.clr_step ? '0 : {bmult_ff, badd_ff, bslots_ff, bbase_ff};

   tph_ram #(.WIDTH(BktWidth), .DEPTH(MAX_BUCKETS)) u_bkt_ram (
      .clock (clock),
      .we    (bkt_we),
      .re    (cmd.bkt_rd),
      .addr  (bkt_addr32[BKT_AW-1:0]),
      .wdata (bkt_wdata),
      .rdata (bkt_rdata)
   );

   assign op_hit = (op_ff == OP_INSERT) || (op_ff == OP_ERASE) || (op_ff == OP_LOAD_SLOT);
   assign new_present = (op_ff == OP_INSERT) ? 1'b1
                      : ((op_ff == OP_ERASE) ? 1'b0 : rd_present);
   assign slot_addr32 = cmd.clr_step ? clr32 : pos32;
   assign slot_we = (cmd.clr_step && clr32 < 32'(SLOT_DEPTH))
                 || (cmd.finish && ok && op_hit);

   always_comb begin
      if (cmd.clr_step) begin
         slot_wdata = '0;
      end else if (op_ff == OP_LOAD_SLOT) begin
         slot_wdata = {key_ff, 1'b1, rd_present};
      end else begin
         slot_wdata = {rd_key, rd_loaded, new_present};
      end
   end

   tph_ram #(.WIDTH(SlotWidth), .DEPTH(SLOT_DEPTH)) u_slot_ram (
      .clock (clock),
      .we    (slot_we),
      .re    (cmd.slot_rd),
      .addr  (slot_addr32[SLOT_AW-1:0]),
      .wdata (slot_wdata),
      .rdata (slot_rdata)
   );

   always_comb begin
      count_in   = count_ff;
      present_in = 1'b0;
      match_in   = 1'b0;
      if (cmd.clr_step || cmd.clr_init) begin
         count_in = '0;
      end else if (cmd.finish && ok) begin
         if (op_ff == OP_INSERT && count_ff != 16'hFFFF) begin
            count_in = count_ff + 16'd1;
         end else if (op_ff == OP_ERASE && count_ff != 16'h0000) begin
            count_in = count_ff - 16'd1;
         end
         if (op_ff == OP_LOOKUP || op_ff == OP_INSERT || op_ff == OP_ERASE) begin
            present_in = new_present;
            match_in   = rd_loaded && (rd_key == key_ff);
         end else if (op_ff == OP_LOAD_SLOT) begin
            present_in = rd_present;
            match_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_op;
         key_ff    <= req_key;
         bidx_ff   <= req_bucket_index;
         bmult_ff  <= req_bucket_mult;
         badd_ff   <= req_bucket_add;
         bslots_ff <= req_bucket_slots;
         bbase_ff  <= req_bucket_base;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.capture) begin
         stat_ff <= ST_OK;
      end else if (cmd.stat_wr) begin
         stat_ff <= cmd.stat_val;
      end
      if (cmd.capture) begin
         slot_pos_ff <= {2'b0, req_slot_index};
      end else if (cmd.pos_en) begin
         slot_pos_ff <= {2'b0, rd_base} + {1'b0, rem};
      end
      if (cmd.bkt_rd) begin
         bkt_inrange_ff <= (b32 < 32'(MAX_BUCKETS));
      end
      if (cmd.finish) begin
         rsp_present_ff      <= present_in;
         rsp_key_match_ff    <= match_in;
         rsp_status_ff       <= stat_ff;
         rsp_stored_count_ff <= count_in;
      end
      if (reset) begin
         top_mult_ff    <= 32'd1;
         top_add_ff     <= '0;
         top_buckets_ff <= 11'd1;
         clr_ff         <= '0;
         count_ff       <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_TOP_MULT:    top_mult_ff    <= csr_wdata;
               CSR_TOP_ADD:     top_add_ff     <= csr_wdata;
               CSR_TOP_BUCKETS: top_buckets_ff <= csr_wdata[10:0];
               default: ;
            endcase
         end
         if (cmd.clr_init) begin
            clr_ff <= '0;
         end else if (cmd.clr_step) begin
            clr_ff <= clr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   assign rsp_present      = rsp_present_ff;
   assign rsp_key_match    = rsp_key_match_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_stored_count = rsp_stored_count_ff;

   assign sts.div_busy  = div_busy;
   assign sts.clr_last  = (clr32 == 32'(CLR_LEN - 1));
   assign sts.bkt_empty = !bkt_inrange_ff || (rd_slots == '0);
   assign sts.slot_ok   = (pos32 < 32'(SLOT_DEPTH));

endmodule

[rtl/core/tph_ctrl.sv]
// ----------------------------------------------------------------------------
// tph_ctrl
// Sequencer: steps each request through the hash levels and store accesses.
// ----------------------------------------------------------------------------
module tph_ctrl import tph_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_op,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  tph_sts_type sts,
   output tph_cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_CLEAR, S_MUL, S_RED, S_DIV, S_BKT_RD, S_BKT_CHK, S_POS, S_SLOT_RD,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic lvl_ff, lvl_in;
   logic clr_rsp_ff, clr_rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      lvl_in       = lvl_ff;
      clr_rsp_in   = clr_rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.lvl      = lvl_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               lvl_in      = 1'b0;
               if (req_op == OP_LOOKUP || req_op == OP_INSERT || req_op == OP_ERASE) begin
                  state_in = S_MUL;
               end else if (req_op == OP_LOAD_SLOT) begin
                  state_in = S_SLOT_RD;
               end else if (req_op == OP_CLEAR) begin
                  cmd.clr_init = 1'b1;
                  clr_rsp_in   = 1'b1;
                  state_in     = S_CLEAR;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = clr_rsp_ff ? S_FINISH : S_IDLE;
            end
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = S_RED;
         end
         S_RED: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (!sts.div_busy) begin
               state_in = lvl_ff ? S_POS : S_BKT_RD;
            end
         end
         S_BKT_RD: begin
            cmd.bkt_rd = 1'b1;
            state_in   = S_BKT_CHK;
         end
         S_BKT_CHK: begin
            if (sts.bkt_empty) begin
               cmd.stat_wr  = 1'b1;
               cmd.stat_val = ST_EMPTY;
               state_in     = S_FINISH;
            end else begin
               lvl_in   = 1'b1;
               state_in = S_MUL;
            end
         end
         S_POS: begin
            cmd.pos_en = 1'b1;
            state_in   = S_SLOT_RD;
         end
         S_SLOT_RD: begin
            if (sts.slot_ok) begin
               cmd.slot_rd = 1'b1;
            end else begin
               cmd.stat_wr  = 1'b1;
               cmd.stat_val = ST_BEYOND;
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               clr_rsp_in   = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         lvl_ff       <= 1'b0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lvl_ff       <= lvl_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/core/two_level_perfect_hash_table.sv]
// ----------------------------------------------------------------------------
// two_level_perfect_hash_table
// Two-level perfect hash table with a flat slot store.
// ----------------------------------------------------------------------------
// One request at a time. Lookup, insert and erase pass through two hash levels
// (only the first when the bucket is empty), each a 32-bit multiply, a
// reduction modulo 2^32+15 and a remainder in one shared bit-serial divider,
// plus bucket and slot store reads. After reset, and for a clear request, a
// clearing pass writes every bucket and slot entry, one per cycle, over
// max(MAX_BUCKETS, SLOT_DEPTH) addresses; no request is taken during it. A
// finished response waits in an output register while the next request is
// taken. Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module two_level_perfect_hash_table import tph_pkg::*; #(
   parameter int unsigned MAX_BUCKETS = DefMaxBuckets,
   parameter int unsigned SLOT_DEPTH  = DefSlotDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_op,
   input  logic [31:0] req_key,
   input  logic [9:0]  req_bucket_index,
   input  logic [31:0] req_bucket_mult,
   input  logic [31:0] req_bucket_add,
   input  logic [12:0] req_bucket_slots,
   input  logic [11:0] req_bucket_base,
   input  logic [11:0] req_slot_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_present,
   output logic        rsp_key_match,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_stored_count
);

   tph_cmd_type cmd;
   tph_sts_type sts;

   assign csr_ready = 1'b1;

   tph_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tph_datapath #(.MAX_BUCKETS(MAX_BUCKETS), .SLOT_DEPTH(SLOT_DEPTH)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_we           (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_op           (req_op),
      .req_key          (req_key),
      .req_bucket_index (req_bucket_index),
      .req_bucket_mult  (req_bucket_mult),
      .req_bucket_add   (req_bucket_add),
      .req_bucket_slots (req_bucket_slots),
      .req_bucket_base  (req_bucket_base),
      .req_slot_index   (req_slot_index),
      .rsp_present      (rsp_present),
      .rsp_key_match    (rsp_key_match),
      .rsp_status       (rsp_status),
      .rsp_stored_count (rsp_stored_count)
   );

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-level perfect hash table. A clocked driver
// feeds requests from a queue, a clocked monitor checks every response
// against a table model kept here, and each phase writes a new top-level
// hash setting while the block is idle.
// ----------------------------------------------------------------------------
module tb import tph_pkg::*; ();

   localparam logic [2:0] OP_SPARE6 = 3'd6;
   localparam logic [2:0] OP_SPARE7 = 3'd7;
   localparam int unsigned NBKT = 1024;
   localparam int unsigned NSLOT = 4096;

   typedef struct {
      logic [2:0]  op;
      logic [31:0] key;
      logic [9:0]  bidx;
      logic [31:0] bmult;
      logic [31:0] badd;
      logic [12:0] bslots;
      logic [11:0] bbase;
      logic [11:0] sidx;
   } req_type;

   typedef struct {
      logic        present;
      logic        match;
      logic [1:0]  status;
      logic [15:0] count;
   } rsp_type;

   typedef struct {
      logic [1:0]  idx;
      logic [31:0] data;
   } csr_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_op = '0;
   logic [31:0] req_key = '0;
   logic [9:0] req_bucket_index = '0;
   logic [31:0] req_bucket_mult = '0;
   logic [31:0] req_bucket_add = '0;
   logic [12:0] req_bucket_slots = '0;
   logic [11:0] req_bucket_base = '0;
   logic [11:0] req_slot_index = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_present;
   logic rsp_key_match;
   logic [1:0] rsp_status;
   logic [15:0] rsp_stored_count;

   two_level_perfect_hash_table i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // table model
   logic [31:0] top_mult = 32'd1;
   logic [31:0] top_add = 32'd0;
   logic [10:0] top_buckets = 11'd1;
   logic [31:0] bk_mult [NBKT];
   logic [31:0] bk_add [NBKT];
   logic [12:0] bk_slots [NBKT];
   logic [11:0] bk_base [NBKT];
   logic [31:0] sl_key [NSLOT];
   bit sl_loaded [NSLOT];
   bit sl_present [NSLOT];
   logic [15:0] key_count = '0;

   req_type pending_reqs [$];
   rsp_type expected_rsps [$];
   csr_type pending_csrs [$];
   int errors = 0;
   bit no_idle = 0;
   int req_gap = 0;
   int rsp_stall = 0;

   function automatic void add_req(input req_type r);
      pending_reqs.insert(pending_reqs.size(), r);
   endfunction

   function automatic void add_csr(input logic [1:0] idx, input logic [31:0] data);
      csr_type c;
      c.idx = idx;
      c.data = data;
      pending_csrs.insert(pending_csrs.size(), c);
   endfunction

   function automatic logic [31:0] fks_hash(input logic [31:0] m, c, n, k);
      logic [63:0] t;
      t = (64'(m) * 64'(k)) & 64'hFFFF_FFFF;
      t = t + 64'(c);
      t = t % 64'd4294967311;
      if (n == 0) return 32'd0;
      return 32'(t % 64'(n));
   endfunction

   function automatic logic [1:0] find_slot(input logic [31:0] k, output int slot);
      logic [31:0] b;
      logic [31:0] pos;
      slot = 0;
      b = fks_hash(top_mult, top_add, 32'(top_buckets), k);
      if (b >= NBKT) return ST_EMPTY;
      if (bk_slots[b] == 0) return ST_EMPTY;
      pos = 32'(bk_base[b]) + fks_hash(bk_mult[b], bk_add[b], 32'(bk_slots[b]), k);
      if (pos >= NSLOT) return ST_BEYOND;
      slot = int'(pos);
      return ST_OK;
   endfunction

   function automatic void clear_table();
      for (int i = 0; i < NBKT; i++) begin
         bk_mult[i] = '0; bk_add[i] = '0; bk_slots[i] = '0; bk_base[i] = '0;
      end
      for (int i = 0; i < NSLOT; i++) begin
         sl_key[i] = '0; sl_loaded[i] = 0; sl_present[i] = 0;
      end
      key_count = '0;
   endfunction

   function automatic rsp_type apply_request(input req_type r);
      rsp_type o;
      int slot;
      o = '{present: 1'b0, match: 1'b0, status: ST_OK, count: '0};
      case (r.op)
         OP_LOOKUP, OP_INSERT, OP_ERASE: begin
            o.status = find_slot(r.key, slot);
            if (o.status == ST_OK) begin
               if (r.op == OP_INSERT) begin
                  sl_present[slot] = 1;
                  if (key_count != 16'hFFFF) key_count++;
               end else if (r.op == OP_ERASE) begin
                  sl_present[slot] = 0;
                  if (key_count != 0) key_count--;
               end
               o.present = sl_present[slot];
               o.match = sl_loaded[slot] && sl_key[slot] == r.key;
            end
         end
         OP_LOAD_BUCKET: begin
            bk_mult[r.bidx] = r.bmult;
            bk_add[r.bidx] = r.badd;
            bk_slots[r.bidx] = r.bslots;
            bk_base[r.bidx] = r.bbase;
         end
         OP_LOAD_SLOT: begin
            sl_key[r.sidx] = r.key;
            sl_loaded[r.sidx] = 1;
            o.present = sl_present[r.sidx];
            o.match = 1'b1;
         end
         OP_CLEAR: clear_table();
         default: ;
      endcase
      o.count = key_count;
      return o;
   endfunction

   // request driver
   always @(posedge clock) begin
      req_type r;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_valid && req_ready) begin
            r = '{req_op, req_key, req_bucket_index, req_bucket_mult, req_bucket_add,
                  req_bucket_slots, req_bucket_base, req_slot_index};
            expected_rsps.insert(expected_rsps.size(), apply_request(r));
         end
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               r = pending_reqs.pop_front();
               req_op <= r.op;
               req_key <= r.key;
               req_bucket_index <= r.bidx;
               req_bucket_mult <= r.bmult;
               req_bucket_add <= r.badd;
               req_bucket_slots <= r.bslots;
               req_bucket_base <= r.bbase;
               req_slot_index <= r.sidx;
               req_valid <= 1'b1;
               req_gap <= no_idle ? 0 : int'($urandom_range(0, 3));
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // configuration driver
   always @(posedge clock) begin
      csr_type c;
      if (reset) begin
         csr_valid <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TOP_MULT: top_mult = csr_wdata;
               CSR_TOP_ADD: top_add = csr_wdata;
               CSR_TOP_BUCKETS: top_buckets = csr_wdata[10:0];
               default: ;
            endcase
         end
         if (!csr_valid || csr_ready) begin
            if (pending_csrs.size() > 0) begin
               c = pending_csrs.pop_front();
               csr_index <= c.idx;
               csr_wdata <= c.data;
               csr_valid <= 1'b1;
            end else begin
               csr_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      rsp_type e;
      int n;
      logic nr;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall <= 0;
      end else begin
         nr = 1'b1;
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected response");
               errors++;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_present !== e.present) begin
                  $error("present: expected %0d actual %0d", e.present, rsp_present);
                  errors++;
               end
               if (rsp_key_match !== e.match) begin
                  $error("key_match: expected %0d actual %0d", e.match, rsp_key_match);
                  errors++;
               end
               if (rsp_status !== e.status) begin
                  $error("status: expected %0d actual %0d", e.status, rsp_status);
                  errors++;
               end
               if (rsp_stored_count !== e.count) begin
                  $error("stored_count: expected %0d actual %0d", e.count, rsp_stored_count);
                  errors++;
               end
            end
            n = no_idle ? 0 : int'($urandom_range(0, 3));
            rsp_stall <= n;
            nr = (n == 0);
         end else if (rsp_stall > 0) begin
            rsp_stall <= rsp_stall - 1;
            nr = (rsp_stall == 1);
         end
         rsp_ready <= nr;
      end
   end

   function automatic req_type rand_req(input logic [2:0] op);
      req_type r;
      r.op = op;
      r.key = $urandom;
      r.bidx = 10'($urandom);
      r.bmult = $urandom;
      r.badd = $urandom;
      r.bslots = 13'($urandom);
      r.bbase = 12'($urandom);
      r.sidx = 12'($urandom);
      return r;
   endfunction

   task automatic drain();
      while (pending_reqs.size() != 0 || pending_csrs.size() != 0 || req_valid ||
             csr_valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic set_top(input logic [31:0] m, a, input logic [10:0] nb);
      add_csr(CSR_TOP_MULT, m);
      add_csr(CSR_TOP_ADD, a);
      add_csr(CSR_TOP_BUCKETS, 32'(nb));
      drain();
   endtask

   task automatic run_phase(input logic [31:0] m, a, input logic [10:0] nb);
      logic [31:0] keys [$];
      req_type r;
      int nload, slot, pick;
      set_top(m, a, nb);
      nload = (nb >= 1 && nb <= 16) ? int'(nb) : 12;
      for (int i = 0; i < nload; i++) begin
         r = rand_req(OP_LOAD_BUCKET);
         if (nb >= 1 && nb <= 16) r.bidx = 10'(i);
         r.bslots = ($urandom_range(0, 9) == 0) ? 13'($urandom) : 13'($urandom_range(0, 9));
         r.bbase = ($urandom_range(0, 4) == 0) ? 12'($urandom) : 12'($urandom_range(0, 3900));
         add_req(r);
      end
      drain();
      for (int i = 0; i < 24; i++) begin
         r = rand_req(OP_LOAD_SLOT);
         keys.insert(keys.size(), r.key);
         if (find_slot(r.key, slot) == ST_OK && $urandom_range(0, 4) != 0)
            r.sidx = 12'(slot);
         add_req(r);
      end
      drain();
      for (int i = 0; i < 70; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 88) begin
            r = rand_req(3'($urandom_range(0, 2)));
            if (pick < 80) r.key = keys[$urandom_range(0, keys.size() - 1)];
         end else if (pick < 92) r = rand_req(OP_LOAD_SLOT);
         else if (pick < 96) r = rand_req(($urandom_range(0, 1) == 0) ? OP_SPARE6 : OP_SPARE7);
         else if (pick < 98) r = rand_req(OP_LOAD_BUCKET);
         else r = rand_req(OP_CLEAR);
         add_req(r);
      end
      drain();
   endtask

   initial begin
      req_type r;
      clear_table();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty table, default top hash: all keys land in bucket zero
      add_req(rand_req(OP_LOOKUP));
      add_req(rand_req(OP_ERASE));
      add_req(rand_req(OP_SPARE6));
      add_req(rand_req(OP_SPARE7));
      r = rand_req(OP_LOAD_SLOT); r.sidx = 12'hFFF; r.key = 32'hFFFF_FFFF;
      add_req(r);
      r = rand_req(OP_LOAD_SLOT); r.sidx = 12'h000; r.key = 32'h0;
      add_req(r);
      r = rand_req(OP_LOAD_BUCKET); r.bidx = 10'd0; r.bmult = 32'd1; r.badd = 32'd0;
      r.bslots = 13'd1; r.bbase = 12'd0;
      add_req(r);
      r = rand_req(OP_INSERT); r.key = 32'h0; add_req(r);
      r = rand_req(OP_LOOKUP); r.key = 32'h0; add_req(r);
      r = rand_req(OP_INSERT); r.key = 32'hFFFF_FFFF; add_req(r);
      r = rand_req(OP_ERASE); r.key = 32'h0; add_req(r);
      r = rand_req(OP_ERASE); r.key = 32'h0; add_req(r);
      r = rand_req(OP_ERASE); r.key = 32'h0; add_req(r);
      r = rand_req(OP_LOAD_BUCKET); r.bidx = 10'd0; r.bmult = 32'hFFFF_FFFF;
      r.badd = 32'hFFFF_FFFF; r.bslots = 13'd4096; r.bbase = 12'hFFF;
      add_req(r);
      add_req(rand_req(OP_LOOKUP));
      add_req(rand_req(OP_INSERT));
      r = rand_req(OP_LOAD_BUCKET); r.bidx = 10'h3FF; r.bslots = 13'd4096; r.bbase = 12'd0;
      add_req(r);
      add_req(rand_req(OP_CLEAR));
      add_req(rand_req(OP_LOOKUP));
      drain();

      run_phase(32'd1, 32'd0, 11'd1);
      run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'd0);
      run_phase(32'd0, 32'h1234_5678, 11'd4);
      no_idle = 1;
      run_phase($urandom, $urandom, 11'd16);
      no_idle = 0;
      run_phase($urandom, $urandom, 11'd2047);
      run_phase($urandom, $urandom, 11'd1024);
      run_phase($urandom, 32'hFFFF_FFFF, 11'($urandom_range(1, 16)));
      run_phase($urandom, $urandom, 11'($urandom_range(2, 8)));

      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
